### src/byte_angle_cordic_atan2_defines.svh
// assertion macros shared by the byte angle atan2 modules
`ifndef BYTE_ANGLE_CORDIC_ATAN2_DEFINES_SVH
`define BYTE_ANGLE_CORDIC_ATAN2_DEFINES_SVH

// antecedent in this cycle implies consequent in the same cycle
`define BAC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define BAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bac_pkg.sv
// types and constants of the byte angle cordic atan2 pipeline
package bac_pkg;

    // number of rotation stages the angle table supports
    localparam int MAX_STEPS = 6;

    // one item in flight between pipeline stages
    typedef struct packed {
        logic              neg;   // x was negative, mirror at the end
        logic        [7:0] mx;    // running x magnitude, unsigned wrap
        logic signed [7:0] y;     // running y, signed wrap
        logic        [7:0] sum;   // accumulated byte angle
    } t_vec;

    // angle step of rotation stage idx, 256 units per turn
    function automatic logic [7:0] step_angle(input int idx);
        logic [7:0] a;
        unique case (idx)
            0:       a = 8'd32;
            1:       a = 8'd19;
            2:       a = 8'd10;
            3:       a = 8'd5;
            4:       a = 8'd3;
            5:       a = 8'd1;
            default: a = 8'd0;
        endcase
        return a;
    endfunction

    // mirror angle for a negative x
    localparam logic [7:0] HALF_TURN = 8'd128;

endpackage

### src/bac_rot.sv
// one cordic vectoring micro-rotation stage with its pipeline register
module bac_rot
    import bac_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_vec i_vec,
    output logic o_valid,
    output t_vec o_vec
);
`include "byte_angle_cordic_atan2_defines.svh"

    localparam logic [7:0] STEP = step_angle(SHIFT);

    logic              r_valid;
    t_vec              r_vec;
    t_vec              n_vec;
    logic        [7:0] xs;
    logic signed [7:0] ys;

    // shifted copies of the current vector
    assign xs = i_vec.mx >> SHIFT;
    assign ys = i_vec.y >>> SHIFT;

    // rotate toward y equal zero, no change when y is already zero
    always_comb begin
        n_vec = i_vec;
        if (!i_vec.y[7] && (i_vec.y != 8'sd0)) begin
            n_vec.mx  = i_vec.mx + 8'(ys);
            n_vec.y   = i_vec.y - $signed(xs);
            n_vec.sum = i_vec.sum + STEP;
        end else if (i_vec.y[7]) begin
            n_vec.mx  = i_vec.mx - 8'(ys);
            n_vec.y   = i_vec.y + $signed(xs);
            n_vec.sum = i_vec.sum - STEP;
        end
    end

    // valid bit is control, payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

    // checks
    `BAC_ASSERT_NEXT(a_valid_moves, i_clk, i_rst_n, i_valid, r_valid, "item lost in stage")
    `BAC_ASSERT_NEXT(a_zero_hold, i_clk, i_rst_n, i_valid && (i_vec.y == 8'sd0),
        (r_vec.y == 8'sd0) && (r_vec.sum == $past(i_vec.sum)) && (r_vec.mx == $past(i_vec.mx)),
        "zero y must pass unchanged")
    `BAC_ASSERT_NEXT(a_sum_step, i_clk, i_rst_n, i_valid && (i_vec.y != 8'sd0),
        (r_vec.sum == $past(i_vec.sum) + STEP) || (r_vec.sum == $past(i_vec.sum) - STEP),
        "angle sum moved by other than one step")

endmodule

### src/byte_angle_cordic_atan2.sv
// top level of the byte angle cordic atan2 pipeline
// Takes a signed vector (i_x_coord, i_y_coord) and returns its angle in o_angle, 256 units
// per full turn. One item is accepted in every cycle: busy is always low. Each result
// appears for one cycle with o_valid high, in the order the items came in. An item
// passes through one register for folding and prescaling (loaded at the accepting edge),
// one register per micro-rotation stage, and one output register for the negative-x
// mirror. Results cannot be held off.
module byte_angle_cordic_atan2
    import bac_pkg::*;
#(
    parameter int ROTATION_STEPS = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic signed [8:0] i_x_coord,
    input  logic signed [7:0] i_y_coord,
    output logic              o_valid,
    output logic        [7:0] o_angle
);
`include "byte_angle_cordic_atan2_defines.svh"

    logic        accept;
    logic        r_pre_valid;
    t_vec        r_pre;
    t_vec        n_pre;
    logic  [8:0] neg_x;
    logic        stg_valid [ROTATION_STEPS+1];
    t_vec        stg_vec   [ROTATION_STEPS+1];
    logic        r_out_valid;
    logic  [7:0] r_angle;
    logic  [7:0] n_angle;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // fold x to an 8-bit magnitude and halve both when it is large
    assign neg_x = -i_x_coord;
    always_comb begin
        n_pre.neg = i_x_coord[8];
        n_pre.mx  = i_x_coord[8] ? neg_x[7:0] : i_x_coord[7:0];
        n_pre.y   = i_y_coord;
        n_pre.sum = '0;
        if (n_pre.mx[7]) begin
            n_pre.mx = n_pre.mx >> 1;
            n_pre.y  = i_y_coord >>> 1;
        end
    end

    // prescale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else begin
            r_pre_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pre <= n_pre;
    end

    assign stg_valid[0] = r_pre_valid;
    assign stg_vec[0]   = r_pre;

    // chain of micro-rotation stages
    for (genvar g = 0; g < ROTATION_STEPS; g++) begin : g_rot
        bac_rot #(
            .SHIFT (g)
        ) u_rot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .i_vec   (stg_vec[g]),
            .o_valid (stg_valid[g+1]),
            .o_vec   (stg_vec[g+1])
        );
    end

    // mirror the angle for a negative x
    assign n_angle = stg_vec[ROTATION_STEPS].neg ? (HALF_TURN - stg_vec[ROTATION_STEPS].sum)
                                                 : stg_vec[ROTATION_STEPS].sum;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= stg_valid[ROTATION_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_angle <= n_angle;
    end

    assign o_valid = r_out_valid;
    assign o_angle = r_angle;

    // checks
    `BAC_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, accept, r_pre_valid, "item not taken in")
    `BAC_ASSERT_NEXT(a_pre_small, i_clk, i_rst_n, accept, !r_pre.mx[7] && (r_pre.sum == 8'd0),
        "prescaled magnitude out of range")
    `BAC_ASSERT_NEXT(a_out_follows, i_clk, i_rst_n, stg_valid[ROTATION_STEPS], o_valid,
        "item lost at output")

endmodule
